>>> hdl/nal_byte_stream_framer_defines.svh
// Assertion helpers for the byte-stream framer.
// Both expect clk and rst_n in scope.
`ifndef NAL_BYTE_STREAM_FRAMER_DEFINES_SVH
`define NAL_BYTE_STREAM_FRAMER_DEFINES_SVH

`define NBSF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer assertion failed");

`define NBSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer assertion failed");

`endif

>>> hdl/nbsf_pkg.sv
`default_nettype none

package nbsf_pkg;

    localparam int BYTE_W    = 8;
    localparam int BITLEN_W  = 27;
    localparam int CFG_W     = 24;
    localparam logic [CFG_W-1:0] CAP_RESET = 24'hFFFFFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [BYTE_W-1:0] SC_ZERO  = 8'h00;
    localparam logic [BYTE_W-1:0] SC_ONE   = 8'h01;
    localparam logic [BYTE_W-1:0] EPB_BYTE = 8'h03;
    localparam int START_CODE_LEN = 4;

    // Positions of the result slots one word can expand into
    localparam int SEQ_LEN     = 7;
    localparam int POS_SC_LAST = 3;
    localparam int POS_EPB     = 4;
    localparam int POS_PAY     = 5;
    localparam int POS_OVF     = 6;

    typedef struct packed {
        logic [BYTE_W-1:0]   data;
        logic                start;
        logic                esc;
        logic                pay;
        logic                ovf;
        logic                last;
        logic [BITLEN_W-1:0] bits;
    } desc_t;

endpackage

`default_nettype wire

>>> hdl/nal_byte_stream_framer.sv
// A word's first result passes its queue entry, then the output byte register.
// Throughput: one result per cycle while the reader pops; a word stays at the
// queue head until its 1 to 5 results leave the single output byte register.
// Plain payload words, when popped, stream at one per cycle via a 4-entry queue.
// Reset: counters, queue pointers and valid flag clear; capacity is 16777215.
`default_nettype none

module nal_byte_stream_framer #(
    parameter int COUNT_BITS = 24
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [nbsf_pkg::BYTE_W-1:0]    data_byte,
    input  wire logic                           first_byte,
    input  wire logic                           last_byte,
    input  wire logic [2:0]                     pad_bits,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [nbsf_pkg::CFG_W-1:0]     capacity_bytes,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [nbsf_pkg::BYTE_W-1:0]         out_byte,
    output logic                                run_last,
    output logic                                unit_done,
    output logic                                overflow,
    output logic [nbsf_pkg::BITLEN_W-1:0]       bit_length
);

    logic            q_wr, q_rd, q_valid;
    nbsf_pkg::desc_t q_wdata, q_rdata;

    assign cfg_ready = 1'b1;

    nbsf_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .first_byte    (first_byte),
        .last_byte     (last_byte),
        .pad_bits      (pad_bits),
        .cfg_valid     (cfg_valid),
        .capacity_bytes(capacity_bytes),
        .q_wr          (q_wr),
        .q_data        (q_wdata)
    );

    nbsf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .full    (full),
        .rd_en   (q_rd),
        .rd_valid(q_valid),
        .rd_data (q_rdata)
    );

    nbsf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_rdata),
        .q_rd      (q_rd),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .unit_done (unit_done),
        .overflow  (overflow),
        .bit_length(bit_length)
    );

endmodule

`default_nettype wire

>>> hdl/nbsf_front.sv
`default_nettype none

module nbsf_front #(
    parameter int COUNT_BITS = 24
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire logic                         full,
    input  wire logic [nbsf_pkg::BYTE_W-1:0]  data_byte,
    input  wire logic                         first_byte,
    input  wire logic                         last_byte,
    input  wire logic [2:0]                   pad_bits,
    input  wire logic                         cfg_valid,
    input  wire logic [nbsf_pkg::CFG_W-1:0]   capacity_bytes,
    output logic                              q_wr,
    output nbsf_pkg::desc_t                   q_data
);

    localparam int CAP_W = (COUNT_BITS < nbsf_pkg::CFG_W) ? COUNT_BITS : nbsf_pkg::CFG_W;

    logic [nbsf_pkg::CFG_W-1:0] capacity_reg;
    logic [COUNT_BITS-1:0]      bo_reg, bo_next;
    logic [1:0]                 zc_reg, zc_next;
    logic                       drop_reg, drop_next;

    logic [COUNT_BITS-1:0] cap_eff, bo_base, bo_esc, bo_new;
    logic [1:0]            zc_base;
    logic                  accept, live, start_ok, esc_need, esc_fit, pay_fit, path_ok;

    always_comb
    begin
        cap_eff  = COUNT_BITS'(capacity_reg[CAP_W-1:0]);
        accept   = push && !full;
        live     = first_byte || !drop_reg;
        start_ok = cap_eff >= COUNT_BITS'(nbsf_pkg::START_CODE_LEN);
        path_ok  = !first_byte || start_ok;

        bo_base  = first_byte ? (start_ok ? COUNT_BITS'(nbsf_pkg::START_CODE_LEN) : '0)
                              : bo_reg;
        zc_base  = first_byte ? 2'd0 : zc_reg;

        esc_need = (zc_base == 2'd2) && (data_byte[7:2] == 6'd0);
        esc_fit  = bo_base < cap_eff;
        bo_esc   = esc_need ? bo_base + COUNT_BITS'(1) : bo_base;
        pay_fit  = bo_esc < cap_eff;
        bo_new   = bo_esc + COUNT_BITS'(1);

        q_data.data  = data_byte;
        q_data.start = first_byte && start_ok;
        q_data.esc   = path_ok && esc_need && esc_fit;
        q_data.pay   = path_ok && (!esc_need || esc_fit) && pay_fit;
        q_data.ovf   = !q_data.pay;
        q_data.last  = last_byte;
        q_data.bits  = nbsf_pkg::BITLEN_W'({bo_new, 3'b000})
                       - nbsf_pkg::BITLEN_W'(pad_bits);

        q_wr = accept && live;

        bo_next   = bo_reg;
        zc_next   = zc_reg;
        drop_next = drop_reg;
        if (q_wr)
        begin
            bo_next = q_data.pay ? bo_new : bo_base;
            if (zc_base < 2'd2)
                zc_next = (data_byte == '0) ? zc_base + 2'd1 : 2'd0;
            else
                zc_next = (data_byte == '0) ? 2'd1 : 2'd0;
            // hold off until the next first word once the unit has ended
            drop_next = q_data.ovf || last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= nbsf_pkg::CAP_RESET;
            bo_reg       <= '0;
            zc_reg       <= 2'd0;
            drop_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                capacity_reg <= capacity_bytes;
            bo_reg   <= bo_next;
            zc_reg   <= zc_next;
            drop_reg <= drop_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/nbsf_queue.sv
`default_nettype none

module nbsf_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  nbsf_pkg::desc_t      wr_data,
    output logic                 full,
    input  wire logic            rd_en,
    output logic                 rd_valid,
    output nbsf_pkg::desc_t      rd_data
);

    nbsf_pkg::desc_t entries_reg [nbsf_pkg::QUEUE_DEPTH];
    logic [nbsf_pkg::QUEUE_AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [nbsf_pkg::QUEUE_AW:0]   cnt_reg, cnt_next;
    logic                          do_wr, do_rd;

    always_comb
    begin
        full     = cnt_reg == (nbsf_pkg::QUEUE_AW + 1)'(nbsf_pkg::QUEUE_DEPTH);
        rd_valid = cnt_reg != '0;
        rd_data  = entries_reg[rp_reg];
        do_wr    = wr_en && !full;
        do_rd    = rd_en && rd_valid;
        wp_next  = do_wr ? wp_reg + 1'b1 : wp_reg;
        rp_next  = do_rd ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (!do_wr && do_rd)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entries_reg[wp_reg] <= wr_data;
    end

endmodule

`default_nettype wire

>>> hdl/nbsf_back.sv
`default_nettype none

`include "nal_byte_stream_framer_defines.svh"

module nbsf_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            q_valid,
    input  nbsf_pkg::desc_t                      q_data,
    output logic                                 q_rd,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [nbsf_pkg::BYTE_W-1:0]          out_byte,
    output logic                                 run_last,
    output logic                                 unit_done,
    output logic                                 overflow,
    output logic [nbsf_pkg::BITLEN_W-1:0]        bit_length
);

    logic [nbsf_pkg::SEQ_LEN-1:0] sent_reg, sent_next;
    logic [nbsf_pkg::SEQ_LEN-1:0] mask, rem, lowbit, rest;
    logic                         valid_reg, valid_next, load;

    logic [nbsf_pkg::BYTE_W-1:0]   byte_reg, byte_next;
    logic                          rlast_reg, rlast_next;
    logic                          done_reg, done_next;
    logic                          ovf_reg, ovf_next;
    logic [nbsf_pkg::BITLEN_W-1:0] bits_reg, bits_next;

    always_comb
    begin
        mask   = {q_data.ovf, q_data.pay, q_data.esc, {4{q_data.start}}};
        rem    = mask & ~sent_reg;
        lowbit = rem & (~rem + 1'b1);
        rest   = rem & ~lowbit;
        load   = q_valid && (!valid_reg || pop);

        byte_next  = byte_reg;
        rlast_next = rlast_reg;
        done_next  = done_reg;
        ovf_next   = ovf_reg;
        bits_next  = bits_reg;
        sent_next  = sent_reg;
        valid_next = valid_reg && !pop;
        q_rd       = 1'b0;

        if (load)
        begin
            valid_next = 1'b1;
            rlast_next = rest == '0;
            ovf_next   = lowbit[nbsf_pkg::POS_OVF];
            done_next  = lowbit[nbsf_pkg::POS_OVF]
                         || (lowbit[nbsf_pkg::POS_PAY] && q_data.last);
            bits_next  = (lowbit[nbsf_pkg::POS_PAY] && q_data.last) ? q_data.bits : '0;
            if (lowbit[nbsf_pkg::POS_PAY])
                byte_next = q_data.data;
            else if (lowbit[nbsf_pkg::POS_EPB])
                byte_next = nbsf_pkg::EPB_BYTE;
            else if (lowbit[nbsf_pkg::POS_SC_LAST])
                byte_next = nbsf_pkg::SC_ONE;
            else
                byte_next = nbsf_pkg::SC_ZERO;
            // retire the word after its final slot, else mark the slot sent
            if (rest == '0)
            begin
                sent_next = '0;
                q_rd      = 1'b1;
            end
            else
            begin
                sent_next = sent_reg | lowbit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sent_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            sent_reg  <= sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        rlast_reg <= rlast_next;
        done_reg  <= done_next;
        ovf_reg   <= ovf_next;
        bits_reg  <= bits_next;
    end

    assign empty      = !valid_reg;
    assign out_byte   = byte_reg;
    assign run_last   = rlast_reg;
    assign unit_done  = done_reg;
    assign overflow   = ovf_reg;
    assign bit_length = bits_reg;

    `NBSF_ASSERT_IMP(a_ovf_ends_unit, valid_reg && ovf_reg,
                     done_reg && rlast_reg && (bits_reg == '0))
    `NBSF_ASSERT_IMP(a_len_only_at_end, valid_reg && (bits_reg != '0), done_reg && rlast_reg)
    `NBSF_ASSERT_IMP(a_partial_needs_head, sent_reg != '0, q_valid)
    `NBSF_ASSERT_NEXT(a_retire_clears, load && (rest == '0), sent_reg == '0)

endmodule

`default_nettype wire

>>> bench/tb_nal_byte_stream_framer.sv
`default_nettype none

module tb_nal_byte_stream_framer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_WORDS   = 120;
    localparam int PHASE_WORDS   = 15;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 80;
    localparam int STALL_LIMIT   = 1000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        logic [nbsf_pkg::BYTE_W-1:0]   out_byte;
        logic                          run_last;
        logic                          unit_done;
        logic                          overflow;
        logic [nbsf_pkg::BITLEN_W-1:0] bit_length;
    } framed_byte_t;

    class framer_scoreboard;
        logic [nbsf_pkg::CFG_W-1:0] capacity = nbsf_pkg::CAP_RESET;
        logic [1:0]       zeros_seen = '0;
        logic [24:0]      emitted = '0;
        bit               discarding = 0;
        framed_byte_t     framed_q[$];
        int               failures = 0;
        int               reported = 0;

        function int pending();
            return framed_q.size();
        endfunction

        // Append one emitted byte, or return 0 when the unit is out of room.
        function bit emit(input logic [nbsf_pkg::BYTE_W-1:0] value);
            framed_byte_t r;
            if (emitted >= {1'b0, capacity})
                return 0;
            r = '{value, 1'b0, 1'b0, 1'b0, '0};
            framed_q.push_back(r);
            emitted++;
            return 1;
        endfunction

        function void raise_overflow();
            framed_byte_t r;
            r = '{8'h00, 1'b1, 1'b1, 1'b1, '0};
            framed_q.push_back(r);
            discarding = 1;
        endfunction

        // Predict the output bytes that one accepted word causes.
        function int note_input(input logic [nbsf_pkg::BYTE_W-1:0] value, input bit is_first,
                                input bit is_last, input logic [2:0] pad);
            int           base;
            framed_byte_t r;
            logic [31:0]  len_bits;
            base = framed_q.size();
            if (is_first) begin
                zeros_seen = '0;
                emitted = '0;
                discarding = 0;
                if (capacity < nbsf_pkg::START_CODE_LEN) begin
                    raise_overflow();
                    return framed_q.size() - base;
                end
                void'(emit(nbsf_pkg::SC_ZERO));
                void'(emit(nbsf_pkg::SC_ZERO));
                void'(emit(nbsf_pkg::SC_ZERO));
                void'(emit(nbsf_pkg::SC_ONE));
            end else if (discarding) begin
                return 0;
            end
            if (zeros_seen < 2) begin
                zeros_seen = (value == 0) ? zeros_seen + 2'd1 : 2'd0;
            end else begin
                // escape a small byte after two zeros
                if (value[7:2] == 0) begin
                    if (!emit(nbsf_pkg::EPB_BYTE)) begin
                        raise_overflow();
                        return framed_q.size() - base;
                    end
                end
                zeros_seen = (value == 0) ? 2'd1 : 2'd0;
            end
            if (!emit(value)) begin
                raise_overflow();
                return framed_q.size() - base;
            end
            r = framed_q.pop_back();
            r.run_last = 1'b1;
            if (is_last) begin
                len_bits = 32'(emitted) * 8 - 32'(pad);
                r.unit_done = 1'b1;
                r.bit_length = len_bits[nbsf_pkg::BITLEN_W-1:0];
                discarding = 1;
            end
            framed_q.push_back(r);
            return framed_q.size() - base;
        endfunction

        function void check_result(input framed_byte_t got);
            framed_byte_t want;
            if (framed_q.size() == 0) begin
                failures++;
                if (reported < REPORT_LIMIT) begin
                    reported++;
                    $display("unexpected output byte %h (last %b done %b ovf %b bits %0d)",
                             got.out_byte, got.run_last, got.unit_done, got.overflow,
                             got.bit_length);
                end
                return;
            end
            want = framed_q.pop_front();
            if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
                got.unit_done !== want.unit_done || got.overflow !== want.overflow ||
                got.bit_length !== want.bit_length) begin
                failures++;
                if (reported < REPORT_LIMIT) begin
                    reported++;
                    $display("mismatch: expected byte %h last %b done %b ovf %b bits %0d",
                             want.out_byte, want.run_last, want.unit_done, want.overflow,
                             want.bit_length);
                    $display("          actual   byte %h last %b done %b ovf %b bits %0d",
                             got.out_byte, got.run_last, got.unit_done, got.overflow,
                             got.bit_length);
                end
            end
        endfunction
    endclass

    logic                          clk = 0;
    logic                          rst_n;
    logic                          push;
    logic                          full;
    logic [nbsf_pkg::BYTE_W-1:0]   data_byte;
    logic                          first_byte;
    logic                          last_byte;
    logic [2:0]                    pad_bits;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [nbsf_pkg::CFG_W-1:0]    capacity_bytes;
    logic                          empty;
    logic                          pop;
    logic [nbsf_pkg::BYTE_W-1:0]   out_byte;
    logic                          run_last;
    logic                          unit_done;
    logic                          overflow;
    logic [nbsf_pkg::BITLEN_W-1:0] bit_length;

    framer_scoreboard sb = new;
    int  tx_idle_pct = 30;
    int  rx_idle_pct = 30;
    bit  hold_request = 0;
    int  words_sent = 0;
    int  stall_cycles = 0;

    nal_byte_stream_framer u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .first_byte     (first_byte),
        .last_byte      (last_byte),
        .pad_bits       (pad_bits),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .capacity_bytes (capacity_bytes),
        .empty          (empty),
        .pop            (pop),
        .out_byte       (out_byte),
        .run_last       (run_last),
        .unit_done      (unit_done),
        .overflow       (overflow),
        .bit_length     (bit_length)
    );

    always #10 clk = ~clk;

    // Offer one input word, with a random gap ahead of it, and predict on accept.
    task automatic send_word(input logic [nbsf_pkg::BYTE_W-1:0] value, input bit is_first,
                             input bit is_last, input logic [2:0] pad);
        if ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        push       <= 1'b1;
        data_byte  <= value;
        first_byte <= is_first;
        last_byte  <= is_last;
        pad_bits   <= pad;
        do
            @(posedge clk);
        while (full);
        void'(sb.note_input(value, is_first, is_last, pad));
        words_sent++;
    endtask

    task automatic set_capacity(input logic [nbsf_pkg::CFG_W-1:0] value);
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // let any dropped word still in flight clear the pipeline
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid      <= 1'b1;
        capacity_bytes <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        sb.capacity = value;
    endtask

    function automatic logic [nbsf_pkg::BYTE_W-1:0] pick_byte();
        case ($urandom_range(9))
            0, 1, 2, 3: return 8'h00;
            4, 5:       return nbsf_pkg::BYTE_W'($urandom_range(3));
            default:    return nbsf_pkg::BYTE_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [nbsf_pkg::CFG_W-1:0] pick_capacity(input int phase);
        case (phase % 8)
            0:       return nbsf_pkg::CAP_RESET;
            1:       return nbsf_pkg::CFG_W'($urandom);
            2:       return nbsf_pkg::CFG_W'($urandom_range(40, 4));
            3:       return '0;
            4:       return nbsf_pkg::CFG_W'($urandom_range(20, 5));
            5:       return nbsf_pkg::CFG_W'(3);
            6:       return nbsf_pkg::CFG_W'(5);
            default: return nbsf_pkg::CFG_W'($urandom_range(200, 30));
        endcase
    endfunction

    task automatic send_unit();
        int len;
        int kind;
        int i;
        kind = $urandom_range(99);
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        if (kind < 85) begin
            for (i = 0; i < len; i++)
                send_word(pick_byte(), i == 0, i == len - 1, 3'($urandom_range(7)));
        end else if (kind < 93) begin
            // unit cut short: the next first word abandons it
            for (i = 0; i < len; i++)
                send_word(pick_byte(), i == 0, 1'b0, 3'($urandom_range(7)));
        end else begin
            for (i = 0; i < len; i++)
                send_word(nbsf_pkg::BYTE_W'($urandom_range(255)), $urandom_range(3) == 0,
                          $urandom_range(3) == 0, 3'($urandom_range(7)));
        end
    endtask

    always @(posedge clk) begin
        framed_byte_t got;
        if (rst_n && pop && !empty) begin
            got = '{out_byte, run_last, unit_done, overflow, bit_length};
            sb.check_result(got);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("no progress for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        pop = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (hold_request) begin
                // hold off the reader so the block backs up and stalls its input
                hold_request = 0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            pop <= ($urandom_range(99) >= rx_idle_pct);
            @(posedge clk);
        end
    end

    initial begin
        int phase;
        int phase_start;
        rst_n          = 1'b0;
        push           = 1'b0;
        data_byte      = '0;
        first_byte     = 1'b0;
        last_byte      = 1'b0;
        pad_bits       = '0;
        cfg_valid      = 1'b0;
        capacity_bytes = nbsf_pkg::CAP_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // words before any first mark continue an implicit unit
        send_word(8'h00, 0, 0, 3'd0);
        send_word(8'h00, 0, 0, 3'd0);
        send_word(8'h03, 0, 0, 3'd0);
        send_word(8'hFF, 0, 1, 3'd3);
        send_word(8'h55, 0, 0, 3'd0);
        // escapes on 02 and 00 after zero pairs, none on 04
        send_word(8'h00, 1, 0, 3'd0);
        send_word(8'h00, 0, 0, 3'd0);
        send_word(8'h02, 0, 0, 3'd0);
        send_word(8'h00, 0, 0, 3'd0);
        send_word(8'h00, 0, 0, 3'd0);
        send_word(8'h00, 0, 0, 3'd0);
        send_word(8'h04, 0, 0, 3'd0);
        send_word(8'h01, 0, 0, 3'd0);
        send_word(8'hFF, 0, 0, 3'd0);
        send_word(8'h80, 0, 1, 3'd7);
        send_word(8'h12, 0, 1, 3'd5);
        send_word(8'hA5, 1, 1, 3'd0);
        // first mark inside a running unit restarts it
        send_word(8'h00, 1, 0, 3'd0);
        send_word(8'h00, 0, 0, 3'd0);
        send_word(8'h01, 1, 0, 3'd0);
        send_word(8'h00, 0, 0, 3'd0);
        // shrink capacity mid-unit: next word overflows
        set_capacity(nbsf_pkg::CFG_W'(6));
        send_word(8'h07, 0, 0, 3'd0);
        send_word(8'h08, 0, 1, 3'd2);
        set_capacity('0);
        send_word(8'h00, 1, 1, 3'd0);
        send_word(8'h09, 0, 0, 3'd0);
        set_capacity(nbsf_pkg::CFG_W'(3));
        send_word(8'h3C, 1, 0, 3'd0);
        set_capacity(nbsf_pkg::CFG_W'(4));
        send_word(8'h33, 1, 0, 3'd0);
        // overflow right after an inserted escape byte
        set_capacity(nbsf_pkg::CFG_W'(7));
        send_word(8'h00, 1, 0, 3'd0);
        send_word(8'h00, 0, 0, 3'd0);
        send_word(8'h00, 0, 1, 3'd1);

        phase = 0;
        while (words_sent < TOTAL_WORDS) begin
            set_capacity(pick_capacity(phase));
            tx_idle_pct = (phase == 0) ? 0 : 30;
            rx_idle_pct = (phase == 0) ? 0 : 30;
            if (phase == 1)
                hold_request = 1;
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS &&
                   words_sent < TOTAL_WORDS)
                send_unit();
            phase++;
        end
        set_capacity(nbsf_pkg::CAP_RESET);

        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

`default_nettype wire
